@@ design/vrt_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types for the voxel ray traversal editor.
// No dependencies; imported by the top level and its checker.
package vrt_pkg;

  // grid size defaults
  localparam int GRID_X_DEF = 64;
  localparam int GRID_Y_DEF = 64;
  localparam int GRID_Z_DEF = 64;

  // port field widths
  localparam int ACT_W   = 2;
  localparam int VOX_W   = 6;
  localparam int ORG_W   = 16;
  localparam int DIR_W   = 16;
  localparam int FACE_W  = 2;
  localparam int REACH_W = 8;

  localparam logic [REACH_W-1:0] REACH_RESET = 8'd100;

  // action codes
  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_BREAK = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PLACE = 2'd2;

  // cell coordinates during the walk, wide enough for any reach
  localparam int CW = 11;
  typedef logic signed [CW-1:0] coord_t;

  // fixed-point widths
  localparam int MAG_W = 16;  // |direction|
  localparam int SSQ_W = 32;  // sum of squares
  localparam int LEN_W = 24;  // direction length, 8 fraction bits
  localparam int TD_W  = 31;  // t step per cell
  localparam int TW    = 41;  // t of next crossing, Q11.30
  localparam logic [TW-1:0] T_NEVER = 41'h100_0000_0000;

  // shift amounts of the dividends
  localparam int SH_TDELTA = 30;
  localparam int SH_TMAX   = 22;
  localparam int SH_SQRT   = 16;
  localparam int SH_RADIUS = 38;

  // shared divide / square-root unit
  localparam int NW   = 48;  // dividend / radicand
  localparam int AW   = 28;  // partial remainder
  localparam int DVW  = 24;  // divisor
  localparam int CNTW = 6;

endpackage

@@ design/voxel_ray_traversal_edit.sv @@
`timescale 1ns / 1ps
// Voxel ray traversal editor: occupancy grid, ray walk and one shared
// divide / square-root unit. Depends on vrt_pkg.
//
//   channel | direction | handshake              | words
//   in      | input     | in_valid / in_ready    | action, voxel_*, origin_*, dir_*
//   out     | output    | out_valid / out_ready  | hit, hit_*, face_*, changed
//   cfg     | input     | cfg_valid / cfg_ready  | max_distance
//
// A write word reads one grid row and writes it back. A ray word first forms
// the sum of squares, then runs each divide (up to seven) and the root in
// the one shared shift-subtract unit, then walks cells, each with one grid
// row read and one check, and last makes the edit.
// After reset a clearing pass writes every grid row with in_ready low; cfg
// writes are taken at all times.
// A finished result waits in the output register; the next input word is
// taken while it waits, but a new result holds until the old one is taken.
module voxel_ray_traversal_edit #(
  parameter int GRID_X = vrt_pkg::GRID_X_DEF,
  parameter int GRID_Y = vrt_pkg::GRID_Y_DEF,
  parameter int GRID_Z = vrt_pkg::GRID_Z_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [vrt_pkg::ACT_W-1:0] action,
  input  logic [vrt_pkg::VOX_W-1:0] voxel_x,
  input  logic [vrt_pkg::VOX_W-1:0] voxel_y,
  input  logic [vrt_pkg::VOX_W-1:0] voxel_z,
  input  logic voxel_value,
  input  logic signed [vrt_pkg::ORG_W-1:0] origin_x,
  input  logic signed [vrt_pkg::ORG_W-1:0] origin_y,
  input  logic signed [vrt_pkg::ORG_W-1:0] origin_z,
  input  logic signed [vrt_pkg::DIR_W-1:0] dir_x,
  input  logic signed [vrt_pkg::DIR_W-1:0] dir_y,
  input  logic signed [vrt_pkg::DIR_W-1:0] dir_z,
  output logic out_valid,
  input  logic out_ready,
  output logic hit,
  output logic [vrt_pkg::VOX_W-1:0] hit_x,
  output logic [vrt_pkg::VOX_W-1:0] hit_y,
  output logic [vrt_pkg::VOX_W-1:0] hit_z,
  output logic signed [vrt_pkg::FACE_W-1:0] face_x,
  output logic signed [vrt_pkg::FACE_W-1:0] face_y,
  output logic signed [vrt_pkg::FACE_W-1:0] face_z,
  output logic changed,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [vrt_pkg::REACH_W-1:0] max_distance
);
  import vrt_pkg::*;

  localparam int XW   = $clog2(GRID_X);
  localparam int YW   = $clog2(GRID_Y);
  localparam int ZW   = $clog2(GRID_Z);
  localparam int ROWS = GRID_Y * GRID_Z;
  localparam int RAW  = $clog2(ROWS);

  // sequencer states
  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_WRD  = 4'd2;
  localparam logic [3:0] S_WCHK = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_JOB  = 4'd5;
  localparam logic [3:0] S_RUN  = 4'd6;
  localparam logic [3:0] S_TEST = 4'd7;
  localparam logic [3:0] S_TCHK = 4'd8;
  localparam logic [3:0] S_PRD  = 4'd9;
  localparam logic [3:0] S_PCHK = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  // jobs of the shared unit: per axis tdelta then tmax, then root, radius
  localparam logic [2:0] JOB_SQRT   = 3'd6;
  localparam logic [2:0] JOB_RADIUS = 3'd7;

  function automatic logic in_grid(coord_t c0, coord_t c1, coord_t c2);
    in_grid = c0 >= 0 && c0 < coord_t'(GRID_X) && c1 >= 0 && c1 < coord_t'(GRID_Y) &&
              c2 >= 0 && c2 < coord_t'(GRID_Z);
  endfunction

  function automatic logic [RAW-1:0] row_of(coord_t y, coord_t z);
    row_of = RAW'($unsigned(y)) * RAW'(GRID_Z) + RAW'($unsigned(z));
  endfunction

  logic [3:0] state;
  logic [YW-1:0] clr_y;
  logic [ZW-1:0] clr_z;
  logic [REACH_W-1:0] reach;

  // latched word
  logic [ACT_W-1:0] act;
  logic vval;
  coord_t cur [3];
  coord_t nb [3];
  logic [7:0] frac [3];
  logic [MAG_W-1:0] mag [3];
  logic neg [3];
  logic nz [3];

  // walk state
  logic [TD_W-1:0] tdelta [3];
  logic [TW-1:0] tmax [3];
  logic [TW-1:0] radius;
  logic [SSQ_W-1:0] sumsq;
  logic [LEN_W-1:0] len;
  logic signed [FACE_W-1:0] face [3];
  logic [1:0] sel;
  logic [1:0] maxis;
  logic first;
  logic hit_f;
  logic chg_f;

  // shared shift-subtract unit
  logic [2:0] job;
  logic [AW-1:0] acc;
  logic [NW-1:0] num;
  logic [NW-1:0] quo;
  logic [DVW-1:0] den;
  logic sq_mode;
  logic [CNTW-1:0] cnt;

  // grid memory, one row of x cells per (y, z)
  logic [GRID_X-1:0] grid_mem [ROWS];
  logic [GRID_X-1:0] rdata;
  logic [RAW-1:0] mem_addr;
  logic [GRID_X-1:0] mem_wdata;
  logic [GRID_X-1:0] mask;
  logic [XW-1:0] bx;
  logic mem_we;
  logic mem_re;
  logic occ;

  always_ff @(posedge clk) begin
    if (mem_we) grid_mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata <= grid_mem[mem_addr];
  end

  always_comb begin
    coord_t cy;
    coord_t cz;
    cy = coord_t'(clr_y);
    cz = coord_t'(clr_z);
    if (state == S_CLR) begin
      mem_addr = row_of(cy, cz);
      bx = '0;
    end else if (state == S_PRD || state == S_PCHK) begin
      mem_addr = row_of(nb[1], nb[2]);
      bx = nb[0][XW-1:0];
    end else begin
      mem_addr = row_of(cur[1], cur[2]);
      bx = cur[0][XW-1:0];
    end
    mask = {{(GRID_X-1){1'b0}}, 1'b1} << bx;
    occ = in_grid(cur[0], cur[1], cur[2]) && rdata[bx];
    mem_re = state == S_WRD || state == S_TEST || state == S_PRD;
    mem_we = 1'b0;
    mem_wdata = rdata;
    case (state)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wdata = (clr_y == '0) ? '1 : '0;
      end
      S_WCHK: begin
        mem_we = 1'b1;
        mem_wdata = vval ? (rdata | mask) : (rdata & ~mask);
      end
      S_TCHK: begin
        mem_we = occ && act == ACT_BREAK;
        mem_wdata = rdata & ~mask;
      end
      S_PCHK: begin
        mem_we = 1'b1;
        mem_wdata = rdata | mask;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // job operands
  logic [1:0] ja;
  logic job_ok;
  logic [8:0] span;
  logic [NW-1:0] dvd;
  logic [DVW-1:0] dvs;

  always_comb begin
    ja = (job[2:1] == 2'd3) ? 2'd0 : job[2:1];
    span = neg[ja] ? {1'b0, frac[ja]} : 9'd256 - {1'b0, frac[ja]};
    case (job)
      JOB_SQRT: begin
        job_ok = sumsq != '0;
        dvd = NW'(sumsq) << SH_SQRT;
        dvs = len;
      end
      JOB_RADIUS: begin
        job_ok = sumsq != '0;
        dvd = NW'(reach) << SH_RADIUS;
        dvs = len;
      end
      default: begin
        job_ok = nz[ja];
        dvd = job[0] ? (NW'(span) << SH_TMAX) : (NW'(1) << SH_TDELTA);
        dvs = DVW'(mag[ja]);
      end
    endcase
  end

  // one step of the unit: restoring divide or digit-by-digit root
  logic [AW-1:0] trial;
  logic [AW-1:0] oper;
  logic [AW:0] diff;
  logic ge;
  logic [AW-1:0] acc_next;
  logic [NW-1:0] quo_next;
  logic [NW-1:0] num_next;

  always_comb begin
    if (sq_mode) begin
      trial = {acc[AW-3:0], num[NW-1:NW-2]};
      oper = {quo[AW-3:0], 2'b01};
      num_next = num << 2;
    end else begin
      trial = {acc[AW-2:0], num[NW-1]};
      oper = AW'(den);
      num_next = num << 1;
    end
    diff = {1'b0, trial} - {1'b0, oper};
    ge = !diff[AW];
    acc_next = ge ? diff[AW-1:0] : trial;
    quo_next = {quo[NW-2:0], ge};
  end

  // axis with the nearest crossing
  logic [1:0] ax;
  always_comb begin
    if (tmax[0] < tmax[1]) ax = (tmax[0] < tmax[2]) ? 2'd0 : 2'd2;
    else ax = (tmax[1] < tmax[2]) ? 2'd1 : 2'd2;
  end

  logic [2*MAG_W-1:0] prod;
  assign prod = mag[maxis] * mag[maxis];

  logic in_fire;
  logic out_load;
  assign in_ready = state == S_IDLE;
  assign cfg_ready = 1'b1;
  assign in_fire = in_valid && in_ready;
  assign out_load = state == S_DONE && (!out_valid || out_ready);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) reach <= REACH_RESET;
    else if (cfg_valid) reach <= max_distance;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      hit <= hit_f;
      hit_x <= hit_f ? cur[0][VOX_W-1:0] : '0;
      hit_y <= hit_f ? cur[1][VOX_W-1:0] : '0;
      hit_z <= hit_f ? cur[2][VOX_W-1:0] : '0;
      face_x <= hit_f ? face[0] : '0;
      face_y <= hit_f ? face[1] : '0;
      face_z <= hit_f ? face[2] : '0;
      changed <= chg_f;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_y <= '0;
      clr_z <= '0;
    end else begin
      case (state)
        S_CLR: begin
          // sweep rows, bottom layer set
          if (clr_z == ZW'(GRID_Z - 1)) begin
            clr_z <= '0;
            clr_y <= clr_y + 1'b1;
            if (clr_y == YW'(GRID_Y - 1)) state <= S_IDLE;
          end else begin
            clr_z <= clr_z + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            case (action)
              ACT_WRITE: state <= S_WRD;
              ACT_BREAK, ACT_PLACE: state <= S_MUL;
              default: state <= S_DONE;
            endcase
          end
        end
        S_WRD: state <= in_grid(cur[0], cur[1], cur[2]) ? S_WCHK : S_DONE;
        S_WCHK: state <= S_DONE;
        S_MUL: if (maxis == 2'd2) state <= S_JOB;
        S_JOB: begin
          if (job_ok) state <= S_RUN;
          else if (job == JOB_RADIUS) state <= S_TEST;
        end
        S_RUN: begin
          if (cnt == '0) state <= (job == JOB_RADIUS) ? S_TEST : S_JOB;
        end
        S_TEST: begin
          if (!first && tmax[sel] > radius) state <= S_DONE;
          else state <= S_TCHK;
        end
        S_TCHK: begin
          if (occ) state <= (act == ACT_BREAK) ? S_DONE : S_PRD;
          else if (sumsq == '0) state <= S_DONE;
          else state <= S_TEST;
        end
        S_PRD: state <= in_grid(nb[0], nb[1], nb[2]) ? S_PCHK : S_DONE;
        S_PCHK: state <= S_DONE;
        S_DONE: if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          act <= action;
          vval <= voxel_value;
          hit_f <= 1'b0;
          chg_f <= 1'b0;
          maxis <= '0;
          sumsq <= '0;
          job <= '0;
          radius <= '0;
          first <= 1'b1;
          for (int a = 0; a < 3; a++) begin
            face[a] <= '0;
            tmax[a] <= T_NEVER;
            tdelta[a] <= '0;
          end
          if (action == ACT_WRITE) begin
            cur[0] <= coord_t'(voxel_x);
            cur[1] <= coord_t'(voxel_y);
            cur[2] <= coord_t'(voxel_z);
          end else begin
            // floor of Q8.8 is the signed integer byte
            cur[0] <= coord_t'($signed(origin_x[15:8]));
            cur[1] <= coord_t'($signed(origin_y[15:8]));
            cur[2] <= coord_t'($signed(origin_z[15:8]));
          end
          frac[0] <= origin_x[7:0];
          frac[1] <= origin_y[7:0];
          frac[2] <= origin_z[7:0];
          neg[0] <= dir_x[DIR_W-1];
          neg[1] <= dir_y[DIR_W-1];
          neg[2] <= dir_z[DIR_W-1];
          nz[0] <= dir_x != '0;
          nz[1] <= dir_y != '0;
          nz[2] <= dir_z != '0;
          mag[0] <= dir_x[DIR_W-1] ? MAG_W'(-dir_x) : MAG_W'(dir_x);
          mag[1] <= dir_y[DIR_W-1] ? MAG_W'(-dir_y) : MAG_W'(dir_y);
          mag[2] <= dir_z[DIR_W-1] ? MAG_W'(-dir_z) : MAG_W'(dir_z);
        end
      end
      S_WCHK: chg_f <= rdata[bx] != vval;
      S_MUL: begin
        sumsq <= sumsq + SSQ_W'(prod);
        maxis <= maxis + 1'b1;
      end
      S_JOB: begin
        if (job_ok) begin
          acc <= '0;
          quo <= '0;
          num <= dvd;
          den <= dvs;
          sq_mode <= job == JOB_SQRT;
          cnt <= (job == JOB_SQRT) ? CNTW'(NW / 2 - 1) : CNTW'(NW - 1);
        end else if (job != JOB_RADIUS) begin
          job <= job + 1'b1;
        end
      end
      S_RUN: begin
        acc <= acc_next;
        quo <= quo_next;
        num <= num_next;
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          case (job)
            JOB_SQRT: len <= LEN_W'(quo_next);
            JOB_RADIUS: radius <= TW'(quo_next);
            default: begin
              if (job[0]) tmax[ja] <= TW'(quo_next);
              else tdelta[ja] <= TD_W'(quo_next);
            end
          endcase
          if (job != JOB_RADIUS) job <= job + 1'b1;
        end
      end
      S_TEST: begin
        // face of the cell just entered, unless the step went past reach
        if (!first && tmax[sel] <= radius) begin
          for (int a = 0; a < 3; a++)
            face[a] <= (2'(a) == sel) ? (neg[sel] ? FACE_W'(1) : -FACE_W'(1)) : '0;
        end
        first <= 1'b0;
      end
      S_TCHK: begin
        if (occ) begin
          hit_f <= 1'b1;
          if (act == ACT_BREAK) chg_f <= 1'b1;
          for (int a = 0; a < 3; a++) nb[a] <= cur[a] + coord_t'(face[a]);
        end else if (sumsq != '0) begin
          // advance along the axis with the nearest crossing
          cur[ax] <= neg[ax] ? cur[ax] - 1'b1 : cur[ax] + 1'b1;
          tmax[ax] <= tmax[ax] + TW'(tdelta[ax]);
          sel <= ax;
        end
      end
      S_PCHK: chg_f <= !rdata[bx];
      default: begin
      end
    endcase
  end

endmodule

@@ design/vrt_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the voxel ray traversal editor, bound to its top level.
// Depends on vrt_pkg.
module vrt_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic hit,
  input logic [vrt_pkg::VOX_W-1:0] hit_x,
  input logic signed [vrt_pkg::FACE_W-1:0] face_x,
  input logic signed [vrt_pkg::FACE_W-1:0] face_y,
  input logic signed [vrt_pkg::FACE_W-1:0] face_z,
  input logic changed
);
  import vrt_pkg::*;

  // clearing pass keeps the input closed straight after reset
  a_clear: assert property (@(posedge clk) !rst && $past(rst) |-> !in_ready)
    else $error("input open during clearing pass");

  // one word at a time: the sequencer is busy after taking a word
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken back to back");

  // a miss carries a zero hit_x and no face
  a_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_x == '0 && face_x == '0 && face_y == '0 && face_z == '0)
    else $error("miss with cell or face");

  // at most one face axis set
  a_face: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({face_x != '0, face_y != '0, face_z != '0}) <= 1)
    else $error("face on more than one axis");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(changed))
    else $error("stalled result changed");

endmodule

bind voxel_ray_traversal_edit vrt_checker u_vrt_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .hit(hit), .hit_x(hit_x),
  .face_x(face_x), .face_y(face_y), .face_z(face_z), .changed(changed)
);
